// File: rtl/viabt_pkg.sv
// viabt_pkg: shared types, codes and constants for the vm integer alu
// no dependencies
package viabt_pkg;

   localparam int LANE_WIDTH_DEF = 32;
   localparam int WORD_WIDTH = 64;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_REM = 3'd4,
      CMD_CMP = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      CMP_EQ = 2'd0,
      CMP_NE = 2'd1,
      CMP_LE = 2'd2,
      CMP_LT = 2'd3
   } cmp_kind_type;

   typedef enum logic [1:0] {
      ERR_OK   = 2'd0,
      ERR_DIV0 = 2'd1,
      ERR_ORD  = 2'd2
   } err_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [1:0]  operand_type;
      logic [1:0]  compare_kind;
      logic [63:0] operand_a;
      logic [63:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [63:0] result;
      logic        taken;
      logic [1:0]  error_code;
   } rsp_type;

   // classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_REM  = 3'd4,
      OP_NONE = 3'd5
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        sgn;
      logic        lanes;
      logic        taken;
      logic [1:0]  error_code;
      logic [63:0] operand_a;
      logic [63:0] operand_b;
   } work_type;

endpackage

// File: rtl/viabt_front.sv
// viabt_front: decodes a request, resolves compares, builds a work entry
// depends on viabt_pkg
module viabt_front
   import viabt_pkg::*;
#(
   parameter int LANE_WIDTH = LANE_WIDTH_DEF
) (
   input  req_type  req,
   output work_type work
);

   localparam int LW = LANE_WIDTH;

   logic [LW-1:0] a0, b0, a1, b1;
   logic          eq, lt, sgn, lanes;

   always_comb begin
      a0 = req.operand_a[LW-1:0];
      b0 = req.operand_b[LW-1:0];
      a1 = req.operand_a[2*LW-1:LW];
      b1 = req.operand_b[2*LW-1:LW];
      sgn = ~req.operand_type[0];
      lanes = req.operand_type[1];
      eq = (a0 == b0) && (!lanes || (a1 == b1));
      if (sgn) begin
         lt = $signed(a0) < $signed(b0);
      end else begin
         lt = a0 < b0;
      end

      work = '0;
      work.sgn = sgn;
      work.lanes = lanes;
      work.operand_a = req.operand_a;
      work.operand_b = req.operand_b;
      work.op = OP_NONE;
      work.error_code = ERR_OK;
      unique case (req.command)
         CMD_ADD: work.op = OP_ADD;
         CMD_SUB: work.op = OP_SUB;
         CMD_MUL: work.op = OP_MUL;
         CMD_DIV: work.op = OP_DIV;
         CMD_REM: work.op = OP_REM;
         CMD_CMP: begin
            case (req.compare_kind)
               CMP_EQ: work.taken = eq;
               CMP_NE: work.taken = ~eq;
               CMP_LE: begin
                  if (lanes) work.error_code = ERR_ORD;
                  else work.taken = lt | eq;
               end
               default: begin
                  if (lanes) work.error_code = ERR_ORD;
                  else work.taken = lt;
               end
            endcase
         end
         default: work.op = OP_NONE;
      endcase
   end

endmodule

// File: rtl/viabt_queue.sv
// viabt_queue: small fifo of work entries between front and back
// depends on viabt_pkg
module viabt_queue
   import viabt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   input  logic     pop,
   output logic     empty,
   output logic     full,
   output work_type head
);

   localparam int AW = $clog2(QUEUE_DEPTH);

   work_type      mem_ff [QUEUE_DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;

   assign empty = (cnt_ff == '0);
   assign full = (cnt_ff == (AW+1)'(QUEUE_DEPTH));
   assign head = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

// File: rtl/viabt_back.sv
// viabt_back: pipelined two-lane execute unit with radix-2 divider stages
// depends on viabt_pkg
module viabt_back
   import viabt_pkg::*;
#(
   parameter int LANE_WIDTH = LANE_WIDTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  work_type in_work,
   output logic     out_valid,
   output rsp_type  out_rsp
);

   localparam int LW = LANE_WIDTH;
   localparam int NS = LW + 2; // prep, LW divide steps, finish

   typedef struct packed {
      op_type        op;
      logic          lanes;
      logic          taken;
      logic [1:0]    error_code;
      logic [1:0]    neg_q;
      logic [1:0]    neg_r;
      logic [1:0]    dz;
      logic [1:0][LW-1:0] rem;
      logic [1:0][LW-1:0] quo;  // shifts in quotient, dividend out
      logic [1:0][LW-1:0] dsr;
      logic [1:0][LW-1:0] arith; // add, sub or mul result
   } stage_type;

   logic      vld_ff [NS];
   stage_type stg_ff [NS];
   stage_type stg_in [NS];
   logic [1:0][LW-1:0] pa, pb;
   logic [1:0][LW-1:0] prod;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         pa[l] = in_work.operand_a[l*LW +: LW];
         pb[l] = in_work.operand_b[l*LW +: LW];
         prod[l] = pa[l] * pb[l];
      end
      // prep stage: arithmetic and divider magnitudes
      stg_in[0] = '0;
      stg_in[0].op = in_work.op;
      stg_in[0].lanes = in_work.lanes;
      stg_in[0].taken = in_work.taken;
      stg_in[0].error_code = in_work.error_code;
      for (int l = 0; l < 2; l++) begin
         case (in_work.op)
            OP_ADD: stg_in[0].arith[l] = pa[l] + pb[l];
            OP_SUB: stg_in[0].arith[l] = pa[l] - pb[l];
            OP_MUL: stg_in[0].arith[l] = prod[l];
            default: stg_in[0].arith[l] = '0;
         endcase
         stg_in[0].neg_q[l] = in_work.sgn & (pa[l][LW-1] ^ pb[l][LW-1]);
         stg_in[0].neg_r[l] = in_work.sgn & pa[l][LW-1];
         stg_in[0].quo[l] = (in_work.sgn && pa[l][LW-1]) ? -pa[l] : pa[l];
         stg_in[0].dsr[l] = (in_work.sgn && pb[l][LW-1]) ? -pb[l] : pb[l];
         stg_in[0].dz[l] = (pb[l] == '0) && (l == 0 || in_work.lanes);
      end
      // one restoring division step per stage
      for (int s = 1; s <= LW; s++) begin
         logic [LW:0] trial;
         stg_in[s] = stg_ff[s-1];
         for (int l = 0; l < 2; l++) begin
            trial = {stg_ff[s-1].rem[l], stg_ff[s-1].quo[l][LW-1]}
                    - {1'b0, stg_ff[s-1].dsr[l]};
            if (!trial[LW]) begin
               stg_in[s].rem[l] = trial[LW-1:0];
               stg_in[s].quo[l] = {stg_ff[s-1].quo[l][LW-2:0], 1'b1};
            end else begin
               stg_in[s].rem[l] = {stg_ff[s-1].rem[l][LW-2:0],
                                   stg_ff[s-1].quo[l][LW-1]};
               stg_in[s].quo[l] = {stg_ff[s-1].quo[l][LW-2:0], 1'b0};
            end
         end
      end
      stg_in[NS-1] = stg_ff[NS-2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) vld_ff[s] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
         for (int s = 1; s < NS; s++) vld_ff[s] <= vld_ff[s-1];
      end
      for (int s = 0; s < NS; s++) stg_ff[s] <= stg_in[s];
   end

   // finish: signs, zero divisor, packing
   stage_type          fin;
   logic [1:0][LW-1:0] lane_res;
   logic               any_dz;
   always_comb begin
      fin = stg_ff[NS-1];
      any_dz = 1'b0;
      for (int l = 0; l < 2; l++) begin
         case (fin.op)
            OP_DIV: lane_res[l] = fin.dz[l] ? '0 :
                                  (fin.neg_q[l] ? -fin.quo[l] : fin.quo[l]);
            OP_REM: lane_res[l] = fin.dz[l] ? '0 :
                                  (fin.neg_r[l] ? -fin.rem[l] : fin.rem[l]);
            default: lane_res[l] = fin.arith[l];
         endcase
         if ((fin.op == OP_DIV || fin.op == OP_REM) && fin.dz[l]) any_dz = 1'b1;
      end
      if (!fin.lanes) lane_res[1] = '0;
      out_rsp = '0;
      out_rsp.result[2*LW-1:0] = {lane_res[1], lane_res[0]};
      out_rsp.taken = fin.taken;
      out_rsp.error_code = any_dz ? ERR_DIV0 : fin.error_code;
      out_valid = vld_ff[NS-1];
   end

endmodule

// File: rtl/vm_integer_alu_with_branch_test.sv
// vm_integer_alu_with_branch_test: top level, front decode, queue, execute pipe
// depends on viabt_pkg, viabt_front, viabt_queue, viabt_back
//
//   channel   ports                        handshake
//   request   req_data                     start high, busy low
//   response  rsp_data                     rsp_strobe, one cycle, no stall
//
// a beat accepted at one edge enters the queue, leaves it the next cycle
// into the execute pipe; it then passes the prep, divide-step and finish
// registers before its response appears with rsp_strobe
// throughput one beat per cycle while busy is low, set by the fully pipelined
// divider stages (one quotient bit per stage); the queue only fills if the
// pipe is held, which never happens since the receiver cannot stall
// reset clears the queue pointers and pipe valid bits; busy follows queue full
module vm_integer_alu_with_branch_test
   import viabt_pkg::*;
#(
   parameter int LANE_WIDTH = LANE_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   work_type front_work, head;
   logic     empty, full, accept, issue;

   assign busy = full;
   assign accept = start & ~busy;
   // back pipe never stalls, so issue whenever an entry waits
   assign issue = ~empty;

   viabt_front #(.LANE_WIDTH(LANE_WIDTH)) u_front (
      .req  (req_data),
      .work (front_work)
   );

   viabt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_work),
      .pop       (issue),
      .empty     (empty),
      .full      (full),
      .head      (head)
   );

   viabt_back #(.LANE_WIDTH(LANE_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (issue),
      .in_work   (head),
      .out_valid (rsp_strobe),
      .out_rsp   (rsp_data)
   );

endmodule

// File: bench/testbench.sv
// testbench: stimulus and checking for the vm integer alu with branch test
// depends on viabt_pkg and vm_integer_alu_with_branch_test
module testbench;
   import viabt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LW = LANE_WIDTH_DEF;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // results still owed by the alu, oldest first
   rsp_type owed_results[$];
   int      fail_count;

   vm_integer_alu_with_branch_test #(.LANE_WIDTH(LW)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #2ms;
      $display("simulation failed");
      $finish;
   end

   // one lane of arithmetic on values of LW bits, signed or unsigned by sgn
   function automatic logic [LW-1:0] lane_calc(input logic [2:0] cmd, input logic sgn,
                                               input logic [LW-1:0] a,
                                               input logic [LW-1:0] b,
                                               inout logic div_zero);
      logic [LW-1:0] mag_a;
      logic [LW-1:0] mag_b;
      logic [LW-1:0] q;
      logic [LW-1:0] r;
      logic          neg_a;
      logic          neg_b;
      neg_a = sgn & a[LW-1];
      neg_b = sgn & b[LW-1];
      mag_a = neg_a ? -a : a;
      mag_b = neg_b ? -b : b;
      case (cmd)
         CMD_ADD: return a + b;
         CMD_SUB: return a - b;
         CMD_MUL: return a * b;
         CMD_DIV, CMD_REM: begin
            if (b == '0) begin
               div_zero = 1'b1;
               return '0;
            end
            q = mag_a / mag_b;
            r = mag_a % mag_b;
            if (cmd == CMD_DIV) return (neg_a != neg_b) ? -q : q;
            return neg_a ? -r : r;
         end
         default: return '0;
      endcase
   endfunction

   // expected response for one request beat
   function automatic rsp_type alu_predict(input req_type rq);
      rsp_type       rs;
      logic          sgn;
      logic          lanes;
      logic          dz;
      logic          eq;
      logic          lt;
      logic [LW-1:0] a0;
      logic [LW-1:0] b0;
      rs = '0;
      sgn = ~rq.operand_type[0];
      lanes = rq.operand_type[1];
      dz = 1'b0;
      a0 = rq.operand_a[LW-1:0];
      b0 = rq.operand_b[LW-1:0];
      if (rq.command <= CMD_REM) begin
         rs.result[LW-1:0] = lane_calc(rq.command, sgn, a0, b0, dz);
         if (lanes)
            rs.result[2*LW-1:LW] = lane_calc(rq.command, sgn, rq.operand_a[2*LW-1:LW],
                                             rq.operand_b[2*LW-1:LW], dz);
         if (dz) rs.error_code = ERR_DIV0;
      end else if (rq.command == CMD_CMP) begin
         eq = (a0 == b0);
         if (lanes) eq = eq && (rq.operand_a[2*LW-1:LW] == rq.operand_b[2*LW-1:LW]);
         lt = sgn ? ($signed(a0) < $signed(b0)) : (a0 < b0);
         case (rq.compare_kind)
            CMP_EQ: rs.taken = eq;
            CMP_NE: rs.taken = ~eq;
            CMP_LE: if (lanes) rs.error_code = ERR_ORD; else rs.taken = lt | eq;
            default: if (lanes) rs.error_code = ERR_ORD; else rs.taken = lt;
         endcase
      end
      return rs;
   endfunction

   // send one beat; start held while busy and left high for the next beat
   task automatic send_beat(input req_type rq);
      start    <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      owed_results.push_back(alu_predict(rq));
   endtask

   // send, sometimes with a random gap after the burst ends
   int burst_left;
   int gap_len;
   task automatic send_paced(input req_type rq);
      send_beat(rq);
      gap_len = 0;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(0, 3) == 0) gap_len = $urandom_range(1, 4);
      end
      if (gap_len > 0) begin
         start <= 1'b0;
         repeat (gap_len) @(posedge clock);
      end
   endtask

   function automatic logic [LW-1:0] pick_lane();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return {1'b1, {(LW-1){1'b0}}};
         3: return {1'b0, {(LW-1){1'b1}}};
         4: return LW'(1);
         5: return LW'($urandom_range(0, 15));
         default: return LW'($urandom);
      endcase
   endfunction

   function automatic req_type make_random();
      req_type rq;
      rq.command      = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                     : 3'($urandom_range(0, 5));
      rq.operand_type = 2'($urandom);
      rq.compare_kind = 2'($urandom);
      rq.operand_a    = {pick_lane(), pick_lane()};
      rq.operand_b    = {pick_lane(), pick_lane()};
      // equal operands so compares take both outcomes
      if ($urandom_range(0, 5) == 0) rq.operand_b = rq.operand_a;
      if ($urandom_range(0, 7) == 0) rq.operand_b[LW-1:0] = rq.operand_a[LW-1:0];
      return rq;
   endfunction

   // response checker: every strobe must match the oldest owed result
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (owed_results.size() == 0) begin
            $error("response with nothing owed");
            fail_count++;
         end else begin
            want = owed_results.pop_front();
            if (rsp_data.result !== want.result) begin
               $error("result expected %h actual %h", want.result, rsp_data.result);
               fail_count++;
            end
            if (rsp_data.taken !== want.taken) begin
               $error("taken expected %b actual %b", want.taken, rsp_data.taken);
               fail_count++;
            end
            if (rsp_data.error_code !== want.error_code) begin
               $error("error_code expected %0d actual %0d", want.error_code,
                      rsp_data.error_code);
               fail_count++;
            end
         end
      end
   end

   // directed corners: every command and type, division edges, compares
   task automatic test_directed();
      req_type rq;
      logic [LW-1:0] mn;
      mn = {1'b1, {(LW-1){1'b0}}};
      for (int c = 0; c <= 7; c++) begin
         rq = '0;
         rq.command = 3'(c);
         rq.operand_type = 2'(c % 4);
         rq.operand_a = '1;
         rq.operand_b = {32'h0000_0003, 32'hFFFF_FFFD};
         send_beat(rq);
      end
      // most negative over minus one, signed scalar and lanes
      rq = '0;
      rq.command = CMD_DIV;
      rq.operand_a = {mn, mn};
      rq.operand_b = '1;
      send_beat(rq);
      rq.operand_type = 2'd2;
      send_beat(rq);
      rq.command = CMD_REM;
      send_beat(rq);
      // divide by zero in one lane only
      rq.command = CMD_DIV;
      rq.operand_type = 2'd3;
      rq.operand_a = {LW'(7), LW'(9)};
      rq.operand_b = {LW'(0), LW'(2)};
      send_beat(rq);
      rq.command = CMD_REM;
      rq.operand_type = 2'd1;
      rq.operand_b = '0;
      send_beat(rq);
      // compares, all kinds on all types
      for (int t = 0; t < 4; t++) begin
         for (int k = 0; k < 4; k++) begin
            rq.command = CMD_CMP;
            rq.operand_type = 2'(t);
            rq.compare_kind = 2'(k);
            rq.operand_a = {LW'(5), mn};
            rq.operand_b = (k[0]) ? {LW'(5), LW'(1)} : {LW'(6), mn};
            send_beat(rq);
         end
      end
   endtask

   // random beats in bursts
   task automatic test_random(input int count);
      burst_left = 0;
      gap_len = 0;
      for (int i = 0; i < count; i++) send_paced(make_random());
      // last beat taken without a gap: drop start at that edge
      if (gap_len == 0) start <= 1'b0;
   endtask

   initial begin
      int guard;
      fail_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(2000);
      // drain, then let the pipe latency pass
      guard = 0;
      while (owed_results.size() != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LW + 10) @(posedge clock);
      if (owed_results.size() != 0) begin
         $error("%0d results never arrived", owed_results.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
